// ===== rtl/slew_limited_p_position_controller_defines.svh =====
// Assertion macros for the slew-limited position controller.
`ifndef SLEW_LIMITED_P_POSITION_CONTROLLER_DEFINES_SVH
`define SLEW_LIMITED_P_POSITION_CONTROLLER_DEFINES_SVH

// Same-cycle implication, clocked on clk, off during reset.
`define SLPC_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, clocked on clk, off during reset.
`define SLPC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/slpc_pkg.sv =====
// Shared types and constants of the slew-limited position controller.
package slpc_pkg;

	localparam int CFG_INDEX_BITS = 3;
	localparam int SPEED_BITS     = 16;
	localparam int LIMIT_BITS     = 15;
	localparam int WORD_BITS      = 16;
	localparam int MS_BITS        = 8;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		CFG_TARGET       = 3'd0,
		CFG_MAX_SPEED    = 3'd1,
		CFG_GAIN         = 3'd2,
		CFG_SETTLE_RANGE = 3'd3,
		CFG_SETTLE_MS    = 3'd4,
		CFG_SLEW_STEP    = 3'd5
	} cfg_idx_t;

	localparam logic [LIMIT_BITS-1:0] RST_MAX_SPEED    = 15'd25600;
	localparam logic [WORD_BITS-1:0]  RST_GAIN         = 16'd492;
	localparam logic [WORD_BITS-1:0]  RST_SETTLE_RANGE = 16'd20;
	localparam logic [WORD_BITS-1:0]  RST_SETTLE_MS    = 16'd100;
	localparam logic [LIMIT_BITS-1:0] RST_SLEW_STEP    = 15'd205;

	typedef struct packed {
		logic [WORD_BITS-1:0]  gain;
		logic [LIMIT_BITS-1:0] step;
		logic [LIMIT_BITS-1:0] lim;
		logic                  fwd;
	} side_cfg_t;

endpackage

// ===== rtl/slpc_side.sv =====
// One drive side: proportional command, slew ramp and speed clamp.
module slpc_side #(
	parameter int ERR_BITS = 25
) (
	input  slpc_pkg::side_cfg_t                   cfg,
	input  logic signed [ERR_BITS-1:0]            err,
	input  logic signed [slpc_pkg::SPEED_BITS-1:0] speed_cur,
	output logic signed [slpc_pkg::SPEED_BITS-1:0] speed_nxt
);
	import slpc_pkg::*;

	localparam int PW = ERR_BITS + WORD_BITS + 1;
	localparam int CW = PW - 4;

	logic signed [PW-1:0] err_x;
	logic signed [PW-1:0] gain_x;
	logic signed [PW-1:0] prod;
	logic signed [CW-1:0] cmd;
	logic signed [CW-1:0] spd;
	logic signed [CW-1:0] step_x;
	logic signed [CW-1:0] lim_x;
	logic signed [CW-1:0] raw;
	logic signed [CW-1:0] clamped;
	logic                 ramp;

	always_comb begin
		err_x   = PW'(err);
		gain_x  = PW'(signed'({1'b0, cfg.gain}));
		prod    = err_x * gain_x;
		cmd     = CW'(prod >>> 4);
		spd     = CW'(speed_cur);
		step_x  = CW'(signed'({1'b0, cfg.step}));
		lim_x   = CW'(signed'({1'b0, cfg.lim}));
		ramp    = cfg.fwd ? (cmd > spd) : (cmd < spd);
		if (ramp) begin
			raw = cfg.fwd ? (spd + step_x) : (spd - step_x);
		end else begin
			raw = cmd;
		end
		if (raw > lim_x) begin
			clamped = lim_x;
		end else if (raw < -lim_x) begin
			clamped = -lim_x;
		end else begin
			clamped = raw;
		end
		speed_nxt = SPEED_BITS'(clamped);
	end

endmodule

// ===== rtl/slew_limited_p_position_controller.sv =====
// Top level of the slew-limited proportional position controller.
// One control tick per input item, one result item per tick. An accepted item
// lands in an input register, where the left and right errors and the settle
// range check are formed; when that register advances, each side multiplies
// its error by the gain, ramps and clamps its speed, and the result register
// takes the drives and done flag. A new item is taken every cycle while the
// result side keeps taking results, so sustained rate is one item per clock.
// While a result waits untaken, the input register holds its item.
// Configuration writes take effect at once and are meant for idle periods.
module slew_limited_p_position_controller #(
	parameter int POSITION_BITS = 24
) (
	input  logic clk,
	input  logic arst_n,
	// config write port
	input  logic                                cfg_we,
	input  logic [slpc_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [((POSITION_BITS > 16) ? POSITION_BITS : 16)-1:0] cfg_data,
	// input items
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// tdata: left_position, right_position, elapsed_ms, zero fill
	input  logic [((2*POSITION_BITS+8+7)/8)*8-1:0] s_axis_tdata,
	// tuser: start_move
	input  logic [0:0]                          s_axis_tuser,
	// result items
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// tdata: left_drive, right_drive
	output logic [31:0]                         m_axis_tdata,
	// tuser: done_res
	output logic [0:0]                          m_axis_tuser
);
	import slpc_pkg::*;

	localparam int P  = POSITION_BITS;
	localparam int EW = P + 1;
	localparam int AW = (EW > WORD_BITS) ? EW : WORD_BITS;

	logic signed [P-1:0]     target_q;
	logic [LIMIT_BITS-1:0]   max_speed_q;
	logic [WORD_BITS-1:0]    gain_q;
	logic [WORD_BITS-1:0]    settle_range_q;
	logic [WORD_BITS-1:0]    settle_ms_q;
	logic [LIMIT_BITS-1:0]   slew_step_q;

	logic signed [SPEED_BITS-1:0] left_speed_q;
	logic signed [SPEED_BITS-1:0] right_speed_q;
	logic [WORD_BITS-1:0]         timer_q;
	logic                         finished_q;

	logic                 valid_s1;
	logic                 start_s1;
	logic signed [EW-1:0] lerr_s1;
	logic signed [EW-1:0] rerr_s1;
	logic                 far_s1;
	logic [MS_BITS-1:0]   ems_s1;

	logic                  m_valid_q;
	logic [SPEED_BITS-1:0] m_left_q;
	logic [SPEED_BITS-1:0] m_right_q;
	logic                  m_done_q;

	logic                 in_take;
	logic                 advance;
	logic signed [P-1:0]  left_pos;
	logic signed [P-1:0]  right_pos;
	logic signed [EW-1:0] lerr_in;
	logic signed [EW-1:0] rerr_in;
	logic [EW-1:0]        labs_in;
	logic                 far_in;

	logic signed [SPEED_BITS-1:0] left_eff;
	logic signed [SPEED_BITS-1:0] right_eff;
	logic [WORD_BITS-1:0]         timer_eff;
	logic                         fin_eff;
	logic signed [SPEED_BITS-1:0] left_nxt;
	logic signed [SPEED_BITS-1:0] right_nxt;
	logic [WORD_BITS:0]           timer_sum;
	logic [WORD_BITS-1:0]         timer_new;
	logic                         fin_new;
	logic                         done_out;
	side_cfg_t                    side_cfg;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q       <= '0;
			max_speed_q    <= RST_MAX_SPEED;
			gain_q         <= RST_GAIN;
			settle_range_q <= RST_SETTLE_RANGE;
			settle_ms_q    <= RST_SETTLE_MS;
			slew_step_q    <= RST_SLEW_STEP;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_TARGET:       target_q       <= cfg_data[P-1:0];
				CFG_MAX_SPEED:    max_speed_q    <= cfg_data[LIMIT_BITS-1:0];
				CFG_GAIN:         gain_q         <= cfg_data[WORD_BITS-1:0];
				CFG_SETTLE_RANGE: settle_range_q <= cfg_data[WORD_BITS-1:0];
				CFG_SETTLE_MS:    settle_ms_q    <= cfg_data[WORD_BITS-1:0];
				CFG_SLEW_STEP:    slew_step_q    <= cfg_data[LIMIT_BITS-1:0];
				default: ;
			endcase
		end
	end

	// handshake
	assign advance       = valid_s1 && (!m_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;
	assign in_take       = s_axis_tvalid && s_axis_tready;

	// input stage: errors and settle range check
	always_comb begin
		left_pos  = s_axis_tdata[P-1:0];
		right_pos = s_axis_tdata[2*P-1:P];
		lerr_in   = EW'(target_q) - EW'(left_pos);
		rerr_in   = EW'(target_q) - EW'(right_pos);
		labs_in   = lerr_in[EW-1] ? EW'(-lerr_in) : EW'(lerr_in);
		far_in    = AW'(labs_in) > AW'(settle_range_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			start_s1 <= s_axis_tuser[0];
			lerr_s1  <= lerr_in;
			rerr_s1  <= rerr_in;
			far_s1   <= far_in;
			ems_s1   <= s_axis_tdata[2*P+MS_BITS-1:2*P];
		end
	end

	// update stage
	always_comb begin
		left_eff  = start_s1 ? '0 : left_speed_q;
		right_eff = start_s1 ? '0 : right_speed_q;
		timer_eff = start_s1 ? '0 : timer_q;
		fin_eff   = start_s1 ? 1'b0 : finished_q;

		side_cfg.gain = gain_q;
		side_cfg.step = slew_step_q;
		side_cfg.lim  = max_speed_q;
		side_cfg.fwd  = target_q > 0;

		timer_sum = {1'b0, timer_eff} + (WORD_BITS+1)'(ems_s1);
		if (far_s1) begin
			timer_new = '0;
		end else if (timer_sum[WORD_BITS]) begin
			timer_new = '1;
		end else begin
			timer_new = timer_sum[WORD_BITS-1:0];
		end
		fin_new  = timer_new > settle_ms_q;
		done_out = fin_eff || fin_new;
	end

	slpc_side #(.ERR_BITS(EW)) u_left (
		.cfg       (side_cfg),
		.err       (lerr_s1),
		.speed_cur (left_eff),
		.speed_nxt (left_nxt)
	);

	slpc_side #(.ERR_BITS(EW)) u_right (
		.cfg       (side_cfg),
		.err       (rerr_s1),
		.speed_cur (right_eff),
		.speed_nxt (right_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_speed_q  <= '0;
			right_speed_q <= '0;
			timer_q       <= '0;
			finished_q    <= 1'b0;
		end else if (advance) begin
			if (fin_eff) begin
				left_speed_q  <= left_eff;
				right_speed_q <= right_eff;
				timer_q       <= timer_eff;
				finished_q    <= 1'b1;
			end else begin
				left_speed_q  <= left_nxt;
				right_speed_q <= right_nxt;
				timer_q       <= timer_new;
				finished_q    <= fin_new;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (advance) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			m_left_q  <= done_out ? '0 : left_nxt;
			m_right_q <= done_out ? '0 : right_nxt;
			m_done_q  <= done_out;
		end
	end

	assign m_axis_tvalid   = m_valid_q;
	assign m_axis_tdata    = {m_right_q, m_left_q};
	assign m_axis_tuser[0] = m_done_q;

`include "slew_limited_p_position_controller_defines.svh"

	`SLPC_ASSERT_IMPL(a_done_zero_drive, m_valid_q && m_done_q, (m_left_q == '0) && (m_right_q == '0), "done result with nonzero drive")
	`SLPC_ASSERT_NEXT(a_finished_sticky, advance && finished_q && !start_s1, m_done_q && finished_q, "finished state lost without start")
	`SLPC_ASSERT_NEXT(a_far_clears_timer, advance && far_s1 && !fin_eff, timer_q == '0, "settle timer not cleared when far")

endmodule

// ===== test/slew_limited_p_position_controller_checker.sv =====
// Drive predictor and result scoreboard for the slew-limited position controller.
module slew_limited_p_position_controller_checker
	import slpc_pkg::*;
#(
	parameter int POSITION_BITS = 24
) (
	input  logic clk,
	input  logic arst_n,
	input  logic                                cfg_we,
	input  logic [CFG_INDEX_BITS-1:0]           cfg_index,
	input  logic [((POSITION_BITS > 16) ? POSITION_BITS : 16)-1:0] cfg_data,
	input  logic                                s_axis_tvalid,
	input  logic                                s_axis_tready,
	// tdata: left_position, right_position, elapsed_ms, zero fill
	input  logic [((2*POSITION_BITS+8+7)/8)*8-1:0] s_axis_tdata,
	// tuser: start_move
	input  logic [0:0]                          s_axis_tuser,
	input  logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// tdata: left_drive, right_drive
	input  logic [31:0]                         m_axis_tdata,
	// tuser: done_res
	input  logic [0:0]                          m_axis_tuser,
	output int                                  mismatches,
	output int                                  outstanding
);

	localparam int P = POSITION_BITS;

	typedef struct packed {
		logic signed [SPEED_BITS-1:0] left;
		logic signed [SPEED_BITS-1:0] right;
		logic                         done;
	} drive_t;

	drive_t expected_drives[$];

	longint target_v, limit_v, gain_v, range_v, settle_v, step_v;
	longint left_speed, right_speed, settle_timer;
	bit     settled;

	initial begin
		mismatches  = 0;
		outstanding = 0;
	end

	task automatic report_mismatch(input string what, input longint got, input longint want);
		if (mismatches < 40)
			$display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
		mismatches++;
	endtask

	function automatic longint ramp_speed(input longint speed, input longint err, input bit fwd);
		longint cmd;
		cmd = (err * gain_v) >>> 4;
		if (fwd)
			speed = (cmd > speed) ? speed + step_v : cmd;
		else
			speed = (cmd < speed) ? speed - step_v : cmd;
		if (speed > limit_v)
			speed = limit_v;
		else if (speed < -limit_v)
			speed = -limit_v;
		return speed;
	endfunction

	task automatic control_tick(input logic start, input logic [((2*P+8+7)/8)*8-1:0] item);
		longint lerr, rerr, labs;
		bit     fwd;
		drive_t d;
		if (start) begin
			left_speed   = 0;
			right_speed  = 0;
			settle_timer = 0;
			settled      = 0;
		end
		if (!settled) begin
			lerr = target_v - longint'($signed(item[P-1:0]));
			rerr = target_v - longint'($signed(item[2*P-1:P]));
			fwd  = target_v > 0;
			left_speed  = ramp_speed(left_speed, lerr, fwd);
			right_speed = ramp_speed(right_speed, rerr, fwd);
			settle_timer += longint'(item[2*P+MS_BITS-1:2*P]);
			if (settle_timer > 65535)
				settle_timer = 65535;
			labs = (lerr < 0) ? -lerr : lerr;
			if (labs > range_v)
				settle_timer = 0;
			if (settle_timer > settle_v)
				settled = 1;
		end
		d.done  = settled;
		d.left  = settled ? '0 : left_speed[SPEED_BITS-1:0];
		d.right = settled ? '0 : right_speed[SPEED_BITS-1:0];
		expected_drives.push_back(d);
	endtask

	always @(posedge clk or negedge arst_n) begin
		drive_t want;
		if (!arst_n) begin
			target_v     = 0;
			limit_v      = longint'(RST_MAX_SPEED);
			gain_v       = longint'(RST_GAIN);
			range_v      = longint'(RST_SETTLE_RANGE);
			settle_v     = longint'(RST_SETTLE_MS);
			step_v       = longint'(RST_SLEW_STEP);
			left_speed   = 0;
			right_speed  = 0;
			settle_timer = 0;
			settled      = 0;
			expected_drives.delete();
			outstanding <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx_t'(cfg_index))
					CFG_TARGET:       target_v = longint'($signed(cfg_data[P-1:0]));
					CFG_MAX_SPEED:    limit_v  = longint'(cfg_data[LIMIT_BITS-1:0]);
					CFG_GAIN:         gain_v   = longint'(cfg_data[WORD_BITS-1:0]);
					CFG_SETTLE_RANGE: range_v  = longint'(cfg_data[WORD_BITS-1:0]);
					CFG_SETTLE_MS:    settle_v = longint'(cfg_data[WORD_BITS-1:0]);
					CFG_SLEW_STEP:    step_v   = longint'(cfg_data[LIMIT_BITS-1:0]);
					default: ;
				endcase
			end
			if (s_axis_tvalid && s_axis_tready)
				control_tick(s_axis_tuser[0], s_axis_tdata);
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_drives.size() == 0) begin
					report_mismatch("unexpected result item, left_drive",
						longint'($signed(m_axis_tdata[15:0])), 0);
				end else begin
					want = expected_drives.pop_front();
					if (m_axis_tdata[15:0] !== want.left)
						report_mismatch("left_drive", longint'($signed(m_axis_tdata[15:0])),
							longint'(want.left));
					if (m_axis_tdata[31:16] !== want.right)
						report_mismatch("right_drive", longint'($signed(m_axis_tdata[31:16])),
							longint'(want.right));
					if (m_axis_tuser[0] !== want.done)
						report_mismatch("done_res", longint'(m_axis_tuser[0]),
							longint'(want.done));
				end
			end
			outstanding <= expected_drives.size();
		end
	end

endmodule

// ===== test/slew_limited_p_position_controller_tb.sv =====
// Stimulus, flow control and verdict for the slew-limited position controller.
module slew_limited_p_position_controller_tb;
	import slpc_pkg::*;

	localparam int     POSITION_BITS = 24;
	localparam int     TICKS         = 1850;
	localparam longint CYCLE_LIMIT   = 600000;
	localparam int     HOLD_CYCLES   = 300;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
	logic [23:0] cfg_data = '0;
	logic        s_valid = 1'b0;
	logic        s_ready;
	logic [55:0] s_data = '0;
	logic [0:0]  s_user = '0;
	logic        m_valid;
	logic        m_ready = 1'b0;
	logic [31:0] m_data;
	logic [0:0]  m_user;
	logic        hold_req = 1'b0;

	int     mismatches;
	int     outstanding;
	longint cycles = 0;
	longint target_now = 0;
	longint range_now = longint'(RST_SETTLE_RANGE);
	int     sent = 0;

	slew_limited_p_position_controller #(.POSITION_BITS(POSITION_BITS)) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_axis_tvalid(s_valid),
		.s_axis_tready(s_ready),
		.s_axis_tdata(s_data),
		.s_axis_tuser(s_user),
		.m_axis_tvalid(m_valid),
		.m_axis_tready(m_ready),
		.m_axis_tdata(m_data),
		.m_axis_tuser(m_user)
	);

	slew_limited_p_position_controller_checker #(.POSITION_BITS(POSITION_BITS)) drive_check (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_axis_tvalid(s_valid),
		.s_axis_tready(s_ready),
		.s_axis_tdata(s_data),
		.s_axis_tuser(s_user),
		.m_axis_tvalid(m_valid),
		.m_axis_tready(m_ready),
		.m_axis_tdata(m_data),
		.m_axis_tuser(m_user),
		.mismatches(mismatches),
		.outstanding(outstanding)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// result side: random ready with one long hold-off on request
	initial begin
		int  seg;
		int  mode;
		bit  held;
		held = 0;
		@(posedge clk);
		forever begin
			if (hold_req && !held) begin
				held = 1;
				m_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			seg  = $urandom_range(1, 50);
			mode = $urandom_range(0, 7);
			repeat (seg) begin
				case (mode)
					0, 1, 2, 3: m_ready <= 1'b1;
					4, 5:       m_ready <= ($urandom_range(0, 3) != 0);
					6:          m_ready <= ($urandom_range(0, 3) == 0);
					default:    m_ready <= 1'b0;
				endcase
				@(posedge clk);
			end
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(4, 40);
	endfunction

	function automatic int unsigned spread(input int unsigned hi, input int unsigned typical);
		case ($urandom_range(0, 9))
			0:       return 0;
			1:       return hi;
			2, 3:    return $urandom_range(0, hi);
			default: return $urandom_range(0, typical);
		endcase
	endfunction

	task automatic send_tick(input logic st, input logic [23:0] lp, input logic [23:0] rp,
			input logic [7:0] ms, input bit burst);
		int gap;
		s_valid <= 1'b1;
		s_data  <= {ms, rp, lp};
		s_user  <= st;
		do @(posedge clk); while (!s_ready);
		gap = burst ? 0 : pick_gap();
		if (gap > 0) begin
			s_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic wait_idle();
		s_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic load_settings(input longint tgt, input int unsigned lim, input int unsigned g,
			input int unsigned rng, input int unsigned sms, input int unsigned stp);
		logic [23:0] vals [6];
		cfg_idx_t    idx;
		wait_idle();
		vals[CFG_TARGET]       = tgt[23:0];
		vals[CFG_MAX_SPEED]    = 24'(lim);
		vals[CFG_GAIN]         = 24'(g);
		vals[CFG_SETTLE_RANGE] = 24'(rng);
		vals[CFG_SETTLE_MS]    = 24'(sms);
		vals[CFG_SLEW_STEP]    = 24'(stp);
		target_now = tgt;
		range_now  = longint'(rng);
		idx = idx.first();
		do begin
			cfg_we    <= 1'b1;
			cfg_index <= idx;
			cfg_data  <= vals[idx];
			@(posedge clk);
			idx = idx.next();
		end while (idx != idx.first());
		cfg_we <= 1'b0;
	endtask

	// one move: ramp toward the target, then hover around it, with some noise
	task automatic run_move(input int n, input bit burst, input bit steady);
		longint lp, rp, ramp_len, w;
		logic   st;
		logic [7:0] ms;
		ramp_len = n / 3 + 1;
		w = range_now + 3;
		if (w > 2000)
			w = 2000;
		for (int k = 0; k < n; k++) begin
			st = (k == 0) || (!steady && $urandom_range(0, 49) == 0);
			if (!steady && $urandom_range(0, 99) < 8) begin
				lp = longint'($urandom);
				rp = longint'($urandom);
				ms = 8'($urandom);
			end else begin
				if (k < ramp_len)
					lp = target_now * k / ramp_len;
				else
					lp = target_now + longint'($urandom_range(0, 32'(2 * w))) - w;
				rp = lp + longint'($urandom_range(0, 100)) - 50;
				ms = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 40));
			end
			if (steady)
				ms = 8'hff;
			send_tick(st, lp[23:0], rp[23:0], ms, burst);
			sent++;
		end
	endtask

	initial begin
		longint tgt;
		int     phase;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: extremes, finishing tick, sticky done, restart
		send_tick(1'b1, 24'h000000, 24'h000000, 8'd0, 1'b0);
		send_tick(1'b0, 24'h7fffff, 24'h800000, 8'd255, 1'b0);
		send_tick(1'b0, 24'h800000, 24'h7fffff, 8'd255, 1'b0);
		send_tick(1'b0, 24'h000000, 24'h000000, 8'd255, 1'b0);
		send_tick(1'b0, 24'h000005, 24'hfffffb, 8'd0, 1'b0);
		send_tick(1'b0, 24'h7fffff, 24'h800000, 8'd255, 1'b0);
		send_tick(1'b1, 24'h000001, 24'h000000, 8'd60, 1'b0);
		send_tick(1'b0, 24'h000000, 24'h000001, 8'd60, 1'b0);

		// large commands toward the top of the range
		load_settings(longint'(8388607), 25600, 65535, 65535, 65535, 25600);
		send_tick(1'b1, 24'h800000, 24'h000000, 8'd0, 1'b0);
		send_tick(1'b0, 24'h000000, 24'h7fffff, 8'd255, 1'b0);
		send_tick(1'b0, 24'h7ffff0, 24'h800000, 8'd255, 1'b0);
		send_tick(1'b0, 24'h7fffff, 24'h7fffff, 8'd1, 1'b0);

		// zero speed limit, zero step, zero range and settle time
		load_settings(-longint'(8388608), 0, 65535, 0, 0, 0);
		send_tick(1'b1, 24'h7fffff, 24'h000000, 8'd200, 1'b0);
		send_tick(1'b0, 24'h800000, 24'h800001, 8'd0, 1'b0);
		send_tick(1'b0, 24'h800000, 24'h7fffff, 8'd1, 1'b0);
		send_tick(1'b0, 24'h000000, 24'h000000, 8'd0, 1'b0);

		// negative target with slow ramp, then zero target
		load_settings(-longint'(3000), 25600, 492, 20, 100, 205);
		send_tick(1'b1, 24'h000000, 24'h000000, 8'd10, 1'b0);
		send_tick(1'b0, 24'hfffc18, 24'hfffc00, 8'd10, 1'b0);
		load_settings(0, 1, 1, 65535, 65535, 1);
		send_tick(1'b1, 24'h000010, 24'hfffff0, 8'd3, 1'b0);
		send_tick(1'b0, 24'hfffff0, 24'h000010, 8'd3, 1'b0);

		phase = 0;
		while (sent < TICKS) begin
			case ($urandom_range(0, 9))
				0:       tgt = 0;
				1:       tgt = longint'(8388607);
				2:       tgt = -longint'(8388608);
				3, 4:    tgt = longint'($signed(24'($urandom)));
				5, 6, 7: tgt = longint'($urandom_range(1, 5000));
				default: tgt = -longint'($urandom_range(1, 5000));
			endcase
			if (phase == 2) begin
				// timer saturation: always close, never long enough
				load_settings(1000, 25600, 492, 65535, 65535, 205);
				run_move(280, 1'b0, 1'b1);
			end else begin
				load_settings(tgt, spread(25600, 25600), spread(65535, 2000),
					spread(65535, 50), spread(65535, 400), spread(25600, 1000));
				if (phase == 1) begin
					hold_req <= 1'b1;
					run_move(150, 1'b1, 1'b0);
				end else begin
					run_move($urandom_range(20, 80), $urandom_range(0, 4) == 0, 1'b0);
				end
			end
			phase++;
		end

		wait_idle();
		repeat (10) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/slpc_pkg.sv
rtl/slpc_side.sv
rtl/slew_limited_p_position_controller.sv
test/slew_limited_p_position_controller_checker.sv
test/slew_limited_p_position_controller_tb.sv
